// ----- src/cru_pkg.sv -----
// Shared types and constants for the condition register unit.
// Depends on nothing; used by cru_exec and condition_register_unit_top.
package cru_pkg;

  // Instruction codes carried in the opcode field.
  localparam logic [3:0] OP_CRAND  = 4'd0;
  localparam logic [3:0] OP_CRANDC = 4'd1;
  localparam logic [3:0] OP_CREQV  = 4'd2;
  localparam logic [3:0] OP_CRNAND = 4'd3;
  localparam logic [3:0] OP_CRNOR  = 4'd4;
  localparam logic [3:0] OP_CROR   = 4'd5;
  localparam logic [3:0] OP_CRORC  = 4'd6;
  localparam logic [3:0] OP_CRXOR  = 4'd7;
  localparam logic [3:0] OP_MCRF   = 4'd8;
  localparam logic [3:0] OP_MCRXR  = 4'd9;
  localparam logic [3:0] OP_MFCR   = 4'd10;
  localparam logic [3:0] OP_MTCRF  = 4'd11;
  localparam logic [3:0] OP_MFSPR  = 4'd12;
  localparam logic [3:0] OP_MTSPR  = 4'd13;

  // Special register numbers (low eight bits of the SPR field).
  localparam logic [7:0] SPR_XER = 8'd1;
  localparam logic [7:0] SPR_LR  = 8'd8;
  localparam logic [7:0] SPR_CTR = 8'd9;

  // XER bits copied to a CR field by mcrxr and then cleared.
  localparam logic [31:0] XER_CR_MASK = 32'hF000_0000;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  dest_sel;
    logic [4:0]  src_a_sel;
    logic [4:0]  src_b_sel;
    logic [7:0]  field_mask;
    logic [31:0] source_value;
  } in_item_t;

  typedef struct packed {
    logic        reg_write;
    logic [31:0] reg_value;
    logic        bad_spr;
    logic [31:0] cr_now;
    logic [31:0] xer_now;
    logic [31:0] link_now;
    logic [31:0] count_now;
  } out_item_t;

  // Architectural state of the unit.
  typedef struct packed {
    logic [31:0] cr;
    logic [31:0] xer;
    logic [31:0] lr;
    logic [31:0] ctr;
  } arch_t;

endpackage

// ----- src/condition_register_unit_top.sv -----
// Condition register unit: executes CR logical, CR move and SPR move instructions.
// Depends on cru_pkg for types and constants and on cru_exec for the execute logic.
//
// Usage:
//   Items enter on in_valid/in_ready/in_data and each produces exactly one result
//   on out_valid/out_ready/out_data. A result carries the general register write
//   (if any), the bad SPR flag and the values of CR, XER, LR and CTR after the item.
//   An item is captured in the input register at acceptance, executes once the
//   result register is free or drains, and its result is registered there and
//   drives out_valid. Throughput is one item per cycle while the receiver does not
//   stall; the next item is taken while a result waits, and the only loop is the
//   update of the architectural registers. When the receiver stalls, the result
//   register holds its item, the input register keeps the next one, and in_ready
//   falls once both are full; nothing is dropped or repeated. Architectural state
//   changes only when an item executes, so items always see the state left by the
//   item before them. Reset (rst_n low, synchronous) clears CR, XER, LR and CTR to
//   zero and empties both registers.
module condition_register_unit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cru_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cru_pkg::out_item_t  out_data
);

  cru_pkg::in_item_t  in_item_r;
  logic               in_vld_r;
  cru_pkg::out_item_t out_item_r;
  logic               out_vld_r;
  cru_pkg::arch_t     arch_r;
  cru_pkg::arch_t     arch_nxt;
  cru_pkg::out_item_t out_item_nxt;
  logic               exec_go;

  // Execute when an item waits and the result register is free or drains now.
  assign exec_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || exec_go;

  cru_exec u_exec (
    .item      (in_item_r),
    .state_cur (arch_r),
    .state_nxt (arch_nxt),
    .result    (out_item_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // Architectural state and result register update together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (exec_go) begin
        arch_r <= arch_nxt;
      end
      if (exec_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (exec_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // A shown result always matches the live architectural registers.
  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.cr_now == arch_r.cr && out_item_r.xer_now == arch_r.xer &&
                   out_item_r.link_now == arch_r.lr && out_item_r.count_now == arch_r.ctr))
    else $error("result state differs from architectural registers");

  // A register write and an SPR error never come together.
  a_wr_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_item_r.reg_write && out_item_r.bad_spr))
    else $error("register write flagged with bad SPR");

  // Without a register write the written value is zero.
  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_item_r.reg_write) |-> (out_item_r.reg_value == 32'd0))
    else $error("nonzero value without register write");

  // State changes only on the cycle after an item executes.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_go |=> $stable(arch_r))
    else $error("architectural state changed without an item");

endmodule

// ----- src/cru_exec.sv -----
// Execute logic of the condition register unit: next state and result of one item.
// Depends on cru_pkg for the item, result and state types and the opcode constants.
module cru_exec (
  input  cru_pkg::in_item_t  item,
  input  cru_pkg::arch_t     state_cur,
  output cru_pkg::arch_t     state_nxt,
  output cru_pkg::out_item_t result
);

  always_comb begin
    logic        bit_a;
    logic        bit_b;
    logic        bit_r;
    logic [4:0]  pos;
    logic [4:0]  dst_base;
    logic [4:0]  src_base;
    logic [31:0] wmask;
    logic [7:0]  spr;
    logic        wr;
    logic [31:0] val;
    logic        bad;

    state_nxt = state_cur;
    wr        = 1'b0;
    val       = '0;
    bad       = 1'b0;

    // CR bit n sits at bit 31-n of the packed register.
    bit_a = state_cur.cr[5'd31 - item.src_a_sel];
    bit_b = state_cur.cr[5'd31 - item.src_b_sel];
    pos   = 5'd31 - item.dest_sel;

    // Field f occupies bits 4*(7-f)+3 .. 4*(7-f).
    dst_base = {3'd7 - item.dest_sel[2:0], 2'b00};
    src_base = {3'd7 - item.src_a_sel[2:0], 2'b00};

    // Expand the mtcrf mask to one nibble per bit.
    for (int i = 0; i < 8; i++) begin
      wmask[4*i +: 4] = {4{item.field_mask[i]}};
    end

    spr = {item.src_b_sel[2:0], item.src_a_sel};

    unique case (item.opcode)
      cru_pkg::OP_CRAND:  bit_r = bit_a & bit_b;
      cru_pkg::OP_CRANDC: bit_r = bit_a & ~bit_b;
      cru_pkg::OP_CREQV:  bit_r = ~(bit_a ^ bit_b);
      cru_pkg::OP_CRNAND: bit_r = ~(bit_a & bit_b);
      cru_pkg::OP_CRNOR:  bit_r = ~(bit_a | bit_b);
      cru_pkg::OP_CROR:   bit_r = bit_a | bit_b;
      cru_pkg::OP_CRORC:  bit_r = bit_a | ~bit_b;
      default:            bit_r = bit_a ^ bit_b;
    endcase

    unique case (item.opcode)
      cru_pkg::OP_CRAND, cru_pkg::OP_CRANDC, cru_pkg::OP_CREQV, cru_pkg::OP_CRNAND,
      cru_pkg::OP_CRNOR, cru_pkg::OP_CROR, cru_pkg::OP_CRORC, cru_pkg::OP_CRXOR: begin
        state_nxt.cr[pos] = bit_r;
      end
      cru_pkg::OP_MCRF: begin
        state_nxt.cr[dst_base +: 4] = state_cur.cr[src_base +: 4];
      end
      cru_pkg::OP_MCRXR: begin
        state_nxt.cr[dst_base +: 4] = state_cur.xer[31:28];
        state_nxt.xer = state_cur.xer & ~cru_pkg::XER_CR_MASK;
      end
      cru_pkg::OP_MFCR: begin
        wr  = 1'b1;
        val = state_cur.cr;
      end
      cru_pkg::OP_MTCRF: begin
        state_nxt.cr = (state_cur.cr & ~wmask) | (item.source_value & wmask);
      end
      cru_pkg::OP_MFSPR: begin
        // An unknown SPR number flags an error and writes nothing.
        priority if (spr == cru_pkg::SPR_XER) begin
          wr  = 1'b1;
          val = state_cur.xer;
        end else if (spr == cru_pkg::SPR_LR) begin
          wr  = 1'b1;
          val = state_cur.lr;
        end else if (spr == cru_pkg::SPR_CTR) begin
          wr  = 1'b1;
          val = state_cur.ctr;
        end else begin
          bad = 1'b1;
        end
      end
      cru_pkg::OP_MTSPR: begin
        priority if (spr == cru_pkg::SPR_XER) begin
          state_nxt.xer = item.source_value;
        end else if (spr == cru_pkg::SPR_LR) begin
          state_nxt.lr = item.source_value;
        end else if (spr == cru_pkg::SPR_CTR) begin
          state_nxt.ctr = item.source_value;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        // Unused codes leave everything as it is.
        wr = 1'b0;
      end
    endcase

    result.reg_write = wr;
    result.reg_value = val;
    result.bad_spr   = bad;
    result.cr_now    = state_nxt.cr;
    result.xer_now   = state_nxt.xer;
    result.link_now  = state_nxt.lr;
    result.count_now = state_nxt.ctr;
  end

endmodule

// ----- tb/condition_register_unit_top_test.sv -----
// Self-checking testbench for condition_register_unit_top: directed and random instructions,
// with results checked against a shadow copy of CR, XER, LR and CTR kept in the bench.
// Depends on cru_pkg for the item types, opcodes and SPR numbers.
module condition_register_unit_top_test;

  // Opcodes that the unit must treat as no-ops.
  localparam logic [3:0] OP_UNUSED_LO = 4'd14;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam logic [7:0] SPR_NONE_0   = 8'd0;
  localparam logic [7:0] SPR_NONE_2   = 8'd2;
  localparam logic [7:0] SPR_NONE_FF  = 8'hFF;
  localparam int         IDLE_LIMIT   = 4000;
  localparam int         RANDOM_ITEMS = 1200;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cru_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cru_pkg::out_item_t out_data;

  // Shadow architectural state, updated as each item is accepted.
  logic [31:0] cr_shadow  = '0;
  logic [31:0] xer_shadow = '0;
  logic [31:0] lr_shadow  = '0;
  logic [31:0] ctr_shadow = '0;

  cru_pkg::out_item_t pending_results[$];
  int                 error_count = 0;
  int                 burst_left  = 0;
  int                 rx_cycle    = 0;
  int                 rx_stall    = 0;

  condition_register_unit_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with a period of 2.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Executes one instruction on the shadow state and returns the result it must produce.
  function automatic cru_pkg::out_item_t execute_instr(cru_pkg::in_item_t it);
    cru_pkg::out_item_t res;
    logic [7:0]         spr;
    logic               bit_a;
    logic               bit_b;
    logic               bit_r;
    logic [31:0]        m;
    int                 fd;
    int                 fs;
    res   = '0;
    spr   = {it.src_b_sel[2:0], it.src_a_sel};
    fd    = int'(it.dest_sel[2:0]);
    fs    = int'(it.src_a_sel[2:0]);
    bit_a = cr_shadow[31 - it.src_a_sel];
    bit_b = cr_shadow[31 - it.src_b_sel];
    bit_r = 1'b0;
    m     = '0;
    case (it.opcode)
      cru_pkg::OP_CRAND, cru_pkg::OP_CRANDC, cru_pkg::OP_CREQV, cru_pkg::OP_CRNAND,
      cru_pkg::OP_CRNOR, cru_pkg::OP_CROR, cru_pkg::OP_CRORC, cru_pkg::OP_CRXOR: begin
        case (it.opcode)
          cru_pkg::OP_CRAND:  bit_r = bit_a & bit_b;
          cru_pkg::OP_CRANDC: bit_r = bit_a & ~bit_b;
          cru_pkg::OP_CREQV:  bit_r = ~(bit_a ^ bit_b);
          cru_pkg::OP_CRNAND: bit_r = ~(bit_a & bit_b);
          cru_pkg::OP_CRNOR:  bit_r = ~(bit_a | bit_b);
          cru_pkg::OP_CROR:   bit_r = bit_a | bit_b;
          cru_pkg::OP_CRORC:  bit_r = bit_a | ~bit_b;
          default:            bit_r = bit_a ^ bit_b;
        endcase
        cr_shadow[31 - it.dest_sel] = bit_r;
      end
      cru_pkg::OP_MCRF: begin
        cr_shadow[(7 - fd) * 4 +: 4] = cr_shadow[(7 - fs) * 4 +: 4];
      end
      cru_pkg::OP_MCRXR: begin
        cr_shadow[(7 - fd) * 4 +: 4] = xer_shadow[31:28];
        xer_shadow = xer_shadow & ~cru_pkg::XER_CR_MASK;
      end
      cru_pkg::OP_MFCR: begin
        res.reg_write = 1'b1;
        res.reg_value = cr_shadow;
      end
      cru_pkg::OP_MTCRF: begin
        for (int i = 0; i < 8; i++) m[4 * i +: 4] = {4{it.field_mask[i]}};
        cr_shadow = (cr_shadow & ~m) | (it.source_value & m);
      end
      cru_pkg::OP_MFSPR: begin
        case (spr)
          cru_pkg::SPR_XER: begin res.reg_write = 1'b1; res.reg_value = xer_shadow; end
          cru_pkg::SPR_LR:  begin res.reg_write = 1'b1; res.reg_value = lr_shadow;  end
          cru_pkg::SPR_CTR: begin res.reg_write = 1'b1; res.reg_value = ctr_shadow; end
          default:          res.bad_spr = 1'b1;
        endcase
      end
      cru_pkg::OP_MTSPR: begin
        case (spr)
          cru_pkg::SPR_XER: xer_shadow = it.source_value;
          cru_pkg::SPR_LR:  lr_shadow  = it.source_value;
          cru_pkg::SPR_CTR: ctr_shadow = it.source_value;
          default:          res.bad_spr = 1'b1;
        endcase
      end
      default: ;
    endcase
    res.cr_now    = cr_shadow;
    res.xer_now   = xer_shadow;
    res.link_now  = lr_shadow;
    res.count_now = ctr_shadow;
    return res;
  endfunction

  function automatic cru_pkg::in_item_t make_item(logic [3:0] op, logic [4:0] d,
                                                  logic [4:0] a, logic [4:0] b,
                                                  logic [7:0] fm, logic [31:0] src);
    cru_pkg::in_item_t it;
    it.opcode       = op;
    it.dest_sel     = d;
    it.src_a_sel    = a;
    it.src_b_sel    = b;
    it.field_mask   = fm;
    it.source_value = src;
    return it;
  endfunction

  // SPR instruction with the number split over the two selectors; b's top bits are free.
  function automatic cru_pkg::in_item_t make_spr_item(logic [3:0] op, logic [7:0] spr,
                                                      logic [1:0] b_hi, logic [31:0] src);
    return make_item(op, 5'($urandom), spr[4:0], {b_hi, spr[7:5]}, 8'($urandom), src);
  endfunction

  // Random instruction, mostly well formed, with SPR numbers weighted toward known ones.
  function automatic cru_pkg::in_item_t random_item();
    cru_pkg::in_item_t it;
    logic [63:0]       raw;
    logic [7:0]        spr;
    raw = {$urandom, $urandom};
    it  = raw[$bits(cru_pkg::in_item_t)-1:0];
    if ($urandom_range(0, 99) < 4) begin
      it.opcode = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
    end else begin
      it.opcode = 4'($urandom_range(0, 13));
    end
    if ((it.opcode == cru_pkg::OP_MFSPR || it.opcode == cru_pkg::OP_MTSPR) &&
        $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 2))
        0:       spr = cru_pkg::SPR_XER;
        1:       spr = cru_pkg::SPR_LR;
        default: spr = cru_pkg::SPR_CTR;
      endcase
      it.src_a_sel = spr[4:0];
      it.src_b_sel = {2'($urandom), spr[7:5]};
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h, expected %08h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Drops valid and leaves the sender idle.
  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offers one item, waits for it to be taken, then keeps the burst pattern going.
  task automatic send_item(cru_pkg::in_item_t it);
    logic taken;
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = in_ready;
      if (taken) pending_results.push_back(execute_instr(it));
      @(posedge clk);
    end while (!taken);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_sender($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 15);
    end
  endtask

  // Holds the sender off until every outstanding result has been delivered.
  task automatic drain_results();
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_cr_logic();
    send_item(make_item(cru_pkg::OP_MTCRF, 5'd0, 5'd0, 5'd0, 8'hFF, 32'hA5C3_0F69));
    send_item(make_item(cru_pkg::OP_CRAND,  5'd0,  5'd0,  5'd31, 8'h00, 32'h0));
    send_item(make_item(cru_pkg::OP_CRANDC, 5'd31, 5'd31, 5'd0,  8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(cru_pkg::OP_CREQV,  5'd15, 5'd2,  5'd3,  8'h5A, 32'h1234_5678));
    send_item(make_item(cru_pkg::OP_CRNAND, 5'd16, 5'd0,  5'd0,  8'h00, 32'h0));
    send_item(make_item(cru_pkg::OP_CRNOR,  5'd7,  5'd31, 5'd31, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(cru_pkg::OP_CROR,   5'd1,  5'd30, 5'd29, 8'h81, 32'h0));
    send_item(make_item(cru_pkg::OP_CRORC,  5'd30, 5'd8,  5'd1,  8'h00, 32'h0));
    send_item(make_item(cru_pkg::OP_CRXOR,  5'd31, 5'd0,  5'd31, 8'h00, 32'h0));
  endtask

  // Field copies, XER-to-CR move and CR read; the selectors carry high bits to be ignored.
  task automatic test_field_moves();
    send_item(make_spr_item(cru_pkg::OP_MTSPR, cru_pkg::SPR_XER, 2'b00, 32'hF123_4567));
    send_item(make_item(cru_pkg::OP_MCRXR, 5'b11111, 5'd0, 5'd0, 8'h00, 32'h0));
    send_item(make_item(cru_pkg::OP_MCRXR, 5'b01000, 5'd0, 5'd0, 8'h00, 32'h0));
    send_item(make_item(cru_pkg::OP_MCRF, 5'b11010, 5'b11111, 5'd0, 8'h00, 32'h0));
    send_item(make_item(cru_pkg::OP_MFCR, 5'd0, 5'd0, 5'd0, 8'h00, 32'h0));
  endtask

  task automatic test_mask_write();
    send_item(make_item(cru_pkg::OP_MTCRF, 5'd0, 5'd0, 5'd0, 8'h00, 32'hFFFF_FFFF));
    send_item(make_item(cru_pkg::OP_MTCRF, 5'd0, 5'd0, 5'd0, 8'h01, 32'hFFFF_FFFF));
    send_item(make_item(cru_pkg::OP_MTCRF, 5'd0, 5'd0, 5'd0, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(cru_pkg::OP_MTCRF, 5'd0, 5'd0, 5'd0, 8'hFF, 32'h0000_0000));
  endtask

  // Known SPRs, an aliased number above 255, and unknown numbers that must change nothing.
  task automatic test_spr_moves();
    send_item(make_spr_item(cru_pkg::OP_MTSPR, cru_pkg::SPR_LR, 2'b00, 32'hFFFF_FFFF));
    send_item(make_spr_item(cru_pkg::OP_MTSPR, cru_pkg::SPR_CTR, 2'b11, 32'h1357_9BDF));
    send_item(make_spr_item(cru_pkg::OP_MFSPR, cru_pkg::SPR_XER, 2'b00, 32'h0));
    send_item(make_spr_item(cru_pkg::OP_MFSPR, cru_pkg::SPR_LR, 2'b01, 32'h0));
    send_item(make_spr_item(cru_pkg::OP_MFSPR, cru_pkg::SPR_CTR, 2'b10, 32'h0));
    send_item(make_spr_item(cru_pkg::OP_MTSPR, SPR_NONE_0, 2'b00, 32'hDEAD_BEEF));
    send_item(make_spr_item(cru_pkg::OP_MFSPR, SPR_NONE_FF, 2'b11, 32'h0));
    send_item(make_spr_item(cru_pkg::OP_MTSPR, SPR_NONE_2, 2'b00, 32'h0BAD_0BAD));
  endtask

  task automatic test_unused_ops();
    send_item(make_item(OP_UNUSED_LO, 5'd31, 5'd31, 5'd31, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_UNUSED_HI, 5'd0, 5'd1, 5'd0, 8'hFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_random();
    repeat (RANDOM_ITEMS) send_item(random_item());
  endtask

  // Receiver readiness cycles through full speed, random, sparse and bursty stall patterns.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
      default: begin
        if (rx_stall > 0) begin
          out_ready <= 1'b0;
          rx_stall  <= rx_stall - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall <= $urandom_range(1, 24);
        end
      end
    endcase
  end

  // Compares each delivered result with the oldest prediction.
  always @(negedge clk) begin : check_results
    cru_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, cr_now", out_data.cr_now, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.reg_write != want.reg_write)
          report_mismatch("reg_write", 32'(out_data.reg_write), 32'(want.reg_write));
        if (out_data.reg_value != want.reg_value)
          report_mismatch("reg_value", out_data.reg_value, want.reg_value);
        if (out_data.bad_spr != want.bad_spr)
          report_mismatch("bad_spr", 32'(out_data.bad_spr), 32'(want.bad_spr));
        if (out_data.cr_now != want.cr_now)
          report_mismatch("cr_now", out_data.cr_now, want.cr_now);
        if (out_data.xer_now != want.xer_now)
          report_mismatch("xer_now", out_data.xer_now, want.xer_now);
        if (out_data.link_now != want.link_now)
          report_mismatch("link_now", out_data.link_now, want.link_now);
        if (out_data.count_now != want.count_now)
          report_mismatch("count_now", out_data.count_now, want.count_now);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("condition_register_unit_top_test: done, errors");
    $finish;
  end

  // Main sequence: reset, directed tests, a full drain, random items, another drain, final check.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cr_logic();
    test_field_moves();
    test_mask_write();
    test_spr_moves();
    test_unused_ops();
    drain_results();
    test_random();
    drain_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", 32'(pending_results.size()), 32'h0);
    if (error_count == 0) begin
      $display("condition_register_unit_top_test: done, clean");
    end else begin
      $display("condition_register_unit_top_test: done, errors");
    end
    $finish;
  end

endmodule
